// ===== rtl/jtf_pkg.sv =====
`timescale 1ns / 1ps
// Package for the true-flag key scanner: phase codes, character constants
// and the key/word byte lookups. No dependencies.
package jtf_pkg;

    localparam int PHASE_W = 4;
    typedef logic [PHASE_W-1:0] phase_t;
    typedef logic [7:0]         byte_t;

    // scan phases: 0..7 key bytes matched, then the colon and word steps
    localparam phase_t PH_IDLE       = phase_t'(0);
    localparam phase_t PH_PRE_COLON  = phase_t'(8);
    localparam phase_t PH_POST_COLON = phase_t'(9);
    localparam phase_t PH_T1         = phase_t'(10);
    localparam phase_t PH_T2         = phase_t'(11);
    localparam phase_t PH_T3         = phase_t'(12);
    localparam phase_t PH_TRUE_DONE  = phase_t'(13);

    localparam byte_t CH_NUL   = 8'h00;
    localparam byte_t CH_TAB   = 8'h09;
    localparam byte_t CH_LF    = 8'h0A;
    localparam byte_t CH_CR    = 8'h0D;
    localparam byte_t CH_SPACE = 8'h20;
    localparam byte_t CH_QUOTE = 8'h22;
    localparam byte_t CH_COMMA = 8'h2C;
    localparam byte_t CH_COLON = 8'h3A;
    localparam byte_t CH_RBRACE = 8'h7D;

    // quoted key "resync", quotes included
    function automatic byte_t key_byte(input logic [2:0] idx);
        byte_t b;
        unique case (idx)
            3'd0:    b = CH_QUOTE;
            3'd1:    b = 8'h72; // r
            3'd2:    b = 8'h65; // e
            3'd3:    b = 8'h73; // s
            3'd4:    b = 8'h79; // y
            3'd5:    b = 8'h6E; // n
            3'd6:    b = 8'h63; // c
            default: b = CH_QUOTE;
        endcase
        return b;
    endfunction

    // word "true"
    function automatic byte_t word_byte(input logic [1:0] idx);
        byte_t b;
        unique case (idx)
            2'd0:    b = 8'h74; // t
            2'd1:    b = 8'h72; // r
            2'd2:    b = 8'h75; // u
            default: b = 8'h65; // e
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/json_true_flag_key_scanner_core.sv =====
`timescale 1ns / 1ps
// The result of a last byte is registered in the result queue; m_tvalid is high in the cycle after its request.
// Throughput: one byte per clock while the result queue is not full; the scan state updates in the accepting cycle.
// A two-entry result queue keeps s_tready high while one result waits.
// Reset (rst_n low, asynchronous): scan at key position zero, no match,
// message open, result queue empty.
// Top level of the true-flag key scanner; depends on jtf_pkg.
module json_true_flag_key_scanner_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  jtf_pkg::byte_t       s_tdata,   // [7:0] msg_byte
    input  logic                 s_tlast,   // is_last
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata    // [0] flag_found, [7:1] zero
);
    import jtf_pkg::*;

    // scan state
    phase_t     phase_reg, phase_next;
    logic       seen_reg, seen_next;
    logic       ended_reg, ended_next;

    // result queue: head in slot 0
    logic [1:0] cnt_reg, cnt_next;
    logic [1:0] q_reg, q_next;

    logic       accept;
    logic       push;
    logic       pop;
    logic       flag;
    logic       is_blank;
    logic       is_space;
    phase_t     restart;
    phase_t     scan_phase;
    logic       scan_seen;

    assign accept   = s_tvalid && s_tready;
    assign push     = accept && s_tlast;
    assign pop      = m_tvalid && m_tready;
    assign s_tready = (cnt_reg != 2'd2);
    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = {7'd0, q_reg[0]};

    assign is_blank = (s_tdata == CH_SPACE) || (s_tdata == CH_TAB);
    assign is_space = is_blank || (s_tdata == CH_CR) || (s_tdata == CH_LF);
    // a failing byte may itself open the key
    assign restart  = (s_tdata == CH_QUOTE) ? phase_t'(1) : PH_IDLE;

    // one byte through the matcher
    always_comb
    begin
        scan_phase = restart;
        scan_seen  = seen_reg;
        if (phase_reg < PH_PRE_COLON)
        begin
            if (s_tdata == key_byte(phase_reg[2:0]))
                scan_phase = phase_reg + phase_t'(1);
        end
        else
        begin
            unique case (phase_reg)
                PH_PRE_COLON:
                begin
                    if (is_blank)
                        scan_phase = phase_reg;
                    else if (s_tdata == CH_COLON)
                        scan_phase = PH_POST_COLON;
                end
                PH_POST_COLON:
                begin
                    if (is_space)
                        scan_phase = phase_reg;
                    else if (s_tdata == word_byte(2'd0))
                        scan_phase = PH_T1;
                end
                PH_T1, PH_T2, PH_T3:
                begin
                    // T1 wants 'r', T2 'u', T3 'e'
                    if (s_tdata == word_byte(phase_reg[1:0] - 2'd1))
                        scan_phase = phase_reg + phase_t'(1);
                end
                PH_TRUE_DONE:
                begin
                    if (is_space || (s_tdata == CH_COMMA) || (s_tdata == CH_RBRACE))
                        scan_seen = 1'b1;
                end
                default:
                begin
                    // unreachable codes act as a failed candidate
                end
            endcase
        end
    end

    // message-level handling: zero byte, trailing bytes, end of message
    always_comb
    begin
        phase_next = phase_reg;
        seen_next  = seen_reg;
        ended_next = ended_reg;
        flag       = 1'b0;
        if (accept)
        begin
            if (!ended_reg)
            begin
                if (s_tdata == CH_NUL)
                begin
                    if (phase_reg == PH_TRUE_DONE)
                        seen_next = 1'b1;
                    ended_next = 1'b1;
                end
                else
                begin
                    phase_next = scan_phase;
                    seen_next  = scan_seen;
                end
            end
            if (s_tlast)
            begin
                // end of message terminates a complete "true"
                flag = seen_next || (!ended_next && (phase_next == PH_TRUE_DONE));
                phase_next = PH_IDLE;
                seen_next  = 1'b0;
                ended_next = 1'b0;
            end
        end
    end

    // result queue next state
    always_comb
    begin
        q_next   = q_reg;
        cnt_next = cnt_reg;
        if (pop)
        begin
            q_next[0] = q_reg[1];
            cnt_next  = cnt_reg - 2'd1;
        end
        if (push)
        begin
            if (cnt_next == 2'd0)
                q_next[0] = flag;
            else
                q_next[1] = flag;
            cnt_next = cnt_next + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            seen_reg  <= 1'b0;
            ended_reg <= 1'b0;
            cnt_reg   <= 2'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            seen_reg  <= seen_next;
            ended_reg <= ended_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

`ifndef SYNTHESIS
    // queue never overfills
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("result queue overflow");

    // a last byte clears the scan state
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tlast) |=> (phase_reg == PH_IDLE && !seen_reg && !ended_reg))
        else $error("state not cleared after last byte");

    // a request with a last byte always leaves a result pending
    a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tlast) |=> m_tvalid)
        else $error("result missing after last byte");

    // the zero-byte mark holds until the message ends
    a_ended_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (ended_reg && !(accept && s_tlast)) |=> ended_reg)
        else $error("end-of-message mark lost");
`endif

endmodule

// ===== test/json_true_flag_key_scanner_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for json_true_flag_key_scanner_core: directed and random
// messages with random gaps and stalls on both streams. Depends on jtf_pkg.
module json_true_flag_key_scanner_core_tb;

    import jtf_pkg::*;

    // quoted key and word, first character in the top byte
    localparam logic [63:0] KEY_TEXT  = "\"resync\"";
    localparam logic [31:0] TRUE_TEXT = "true";

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    byte_t       s_tdata  = CH_NUL;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;

    // shadow of the scanner state
    logic [4:0]  pred_phase  = 5'd0;
    bit          pred_hit    = 1'b0;
    bit          pred_closed = 1'b0;

    bit          expected_flags[$];
    byte_t       msg_bytes[$];
    int          mismatches  = 0;
    int          bytes_sent  = 0;
    int          stall_left  = 0;
    bit          steady      = 1'b0;   // no idling on either side while set

    json_true_flag_key_scanner_core u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    function automatic logic [4:0] key_restart(input byte_t c);
        return (c == CH_QUOTE) ? 5'd1 : 5'd0;
    endfunction

    function automatic bit is_blank(input byte_t c);
        return c == CH_SPACE || c == CH_TAB;
    endfunction

    function automatic bit is_space(input byte_t c);
        return is_blank(c) || c == CH_CR || c == CH_LF;
    endfunction

    task automatic advance_scan(input byte_t c);
        byte_t want;
        if (pred_phase < 5'(PH_PRE_COLON))
        begin
            want = KEY_TEXT[8*(7 - pred_phase) +: 8];
            pred_phase = (c == want) ? pred_phase + 5'd1 : key_restart(c);
        end
        else if (pred_phase == 5'(PH_PRE_COLON))
        begin
            if (c == CH_COLON)
                pred_phase = 5'(PH_POST_COLON);
            else if (!is_blank(c))
                pred_phase = key_restart(c);
        end
        else if (pred_phase == 5'(PH_POST_COLON))
        begin
            if (c == TRUE_TEXT[31:24])
                pred_phase = 5'(PH_T1);
            else if (!is_space(c))
                pred_phase = key_restart(c);
        end
        else if (pred_phase < 5'(PH_TRUE_DONE))
        begin
            // T1..T3 wait for r, u, e
            want = TRUE_TEXT[8*(3 - (pred_phase - 5'(PH_POST_COLON))) +: 8];
            pred_phase = (c == want) ? pred_phase + 5'd1 : key_restart(c);
        end
        else
        begin
            if (pred_phase == 5'(PH_TRUE_DONE)
                && (c == CH_COMMA || c == CH_RBRACE || is_space(c)))
                pred_hit = 1'b1;
            pred_phase = key_restart(c);
        end
    endtask

    task automatic predict_request(input byte_t c, input bit last);
        if (!pred_closed)
        begin
            if (c == CH_NUL)
            begin
                // NUL ends the message and terminates a pending "true"
                if (pred_phase == 5'(PH_TRUE_DONE))
                    pred_hit = 1'b1;
                pred_closed = 1'b1;
            end
            else
                advance_scan(c);
        end
        if (last)
        begin
            if (!pred_closed && pred_phase == 5'(PH_TRUE_DONE))
                pred_hit = 1'b1;
            expected_flags.push_back(pred_hit);
            pred_phase  = 5'd0;
            pred_hit    = 1'b0;
            pred_closed = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // stream drivers and result check
    // ------------------------------------------------------------------

    // mostly short gaps, now and then a long one
    function automatic int idle_len(input int zero_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < zero_pct)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    task automatic send_byte(input byte_t c, input bit last);
        int gap;
        bit accepted;
        gap = steady ? 0 : idle_len(55);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= byte_t'($urandom);
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        accepted = 1'b0;
        // inputs only move at rising edges, so the falling edge shows the
        // values the next rising edge will see
        while (!accepted)
        begin
            @(negedge clk);
            accepted = s_tready;
            if (accepted)
                predict_request(c, last);
            @(posedge clk);
        end
        bytes_sent++;
    endtask

    task automatic send_message();
        int i;
        for (i = 0; i < msg_bytes.size(); i++)
            send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
    endtask

    always @(posedge clk)
    begin : ready_gen
        int n;
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (steady)
            m_tready <= 1'b1;
        else
        begin
            n = idle_len(75);
            m_tready   <= (n == 0);
            stall_left <= (n == 0) ? 0 : n - 1;
        end
    end

    always @(negedge clk)
    begin : result_check
        bit want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_flags.size() == 0)
            begin
                $error("flag_found: no result expected, actual %0d", m_tdata[0]);
                mismatches++;
            end
            else
            begin
                want = expected_flags.pop_front();
                if (m_tdata[0] !== want)
                begin
                    $error("flag_found: expected %0d, actual %0b", want, m_tdata[0]);
                    mismatches++;
                end
                if (m_tdata[7:1] !== 7'd0)
                begin
                    $error("m_tdata pad: expected 0, actual %h", m_tdata[7:1]);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // message building
    // ------------------------------------------------------------------

    function automatic byte_t ws_byte();
        case ($urandom_range(0, 3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    // filler text leaning toward the bytes the scanner cares about
    function automatic byte_t text_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return CH_NUL;
        if (r < 10)
            return CH_QUOTE;
        if (r < 16)
            return ws_byte();
        if (r < 20)
            return CH_COLON;
        if (r < 26)
            return KEY_TEXT[8*$urandom_range(0, 7) +: 8];
        return byte_t'($urandom_range(1, 255));
    endfunction

    task automatic push_maybe_broken(input byte_t c, input int pct);
        if ($urandom_range(0, 99) < pct)
            msg_bytes.push_back(byte_t'($urandom));
        else
            msg_bytes.push_back(c);
    endtask

    task automatic push_key(input int pct);
        int i;
        for (i = 0; i < 8; i++)
            push_maybe_broken(KEY_TEXT[8*(7 - i) +: 8], pct);
    endtask

    task automatic push_true(input int pct);
        int i;
        for (i = 0; i < 4; i++)
            push_maybe_broken(TRUE_TEXT[8*(3 - i) +: 8], pct);
    endtask

    // filler, maybe a cut-off key, then key / blanks / colon / space / true
    // and a terminator drawn from the good and the bad ones
    task automatic build_candidate();
        int n;
        int term;
        int i;
        msg_bytes.delete();
        repeat ($urandom_range(0, 5)) msg_bytes.push_back(text_byte());
        if ($urandom_range(0, 3) == 0)
        begin
            n = $urandom_range(1, 7);
            for (i = 0; i < n; i++)
                msg_bytes.push_back(KEY_TEXT[8*(7 - i) +: 8]);
        end
        push_key(2);
        repeat ($urandom_range(0, 3))
            msg_bytes.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
        if ($urandom_range(0, 19) == 0)
            msg_bytes.push_back(CH_LF);     // line break not allowed before colon
        push_maybe_broken(CH_COLON, 5);
        repeat ($urandom_range(0, 3)) msg_bytes.push_back(ws_byte());
        push_true(3);
        term = $urandom_range(0, 9);
        case (term)
            0: msg_bytes.push_back(CH_COMMA);
            1: msg_bytes.push_back(CH_RBRACE);
            2: msg_bytes.push_back(CH_SPACE);
            3: msg_bytes.push_back(CH_TAB);
            4: msg_bytes.push_back(CH_CR);
            5: msg_bytes.push_back(CH_LF);
            6: msg_bytes.push_back(CH_NUL);
            7: return;                      // end of message closes "true"
            8: msg_bytes.push_back(byte_t'($urandom_range(1, 255)));
            default: msg_bytes.push_back(CH_QUOTE);
        endcase
        repeat ($urandom_range(0, 6)) msg_bytes.push_back(text_byte());
        // a second full candidate, ignored when a NUL came first
        if ($urandom_range(0, 6) == 0)
        begin
            push_key(0);
            msg_bytes.push_back(CH_COLON);
            push_true(0);
            msg_bytes.push_back(CH_RBRACE);
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    task automatic test_edge_bytes();
        send_byte(8'hFF, 1'b1);
        send_byte(CH_NUL, 1'b1);
    endtask

    task automatic test_match_at_end();
        msg_bytes.delete();
        push_key(0);
        msg_bytes.push_back(CH_COLON);
        push_true(0);
        send_message();
    endtask

    task automatic test_nul_terminator();
        msg_bytes.delete();
        push_key(0);
        msg_bytes.push_back(CH_COLON);
        push_true(0);
        msg_bytes.push_back(CH_NUL);
        msg_bytes.push_back(8'hFF);
        send_message();
    endtask

    task automatic test_candidate_messages(input int byte_goal);
        while (bytes_sent < byte_goal)
        begin
            steady = ($urandom_range(0, 4) == 0);
            build_candidate();
            send_message();
        end
        steady = 1'b0;
    endtask

    task automatic test_raw_bytes(input int count);
        int i;
        byte_t c;
        for (i = 0; i < count; i++)
        begin
            c = $urandom_range(0, 1) ? byte_t'($urandom) : text_byte();
            send_byte(c, (i == count - 1) || ($urandom_range(0, 11) == 0));
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_edge_bytes();
        test_match_at_end();
        test_nul_terminator();
        test_candidate_messages(1530);
        test_raw_bytes(350);

        s_tvalid <= 1'b0;
        while (expected_flags.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
